// File: hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and helper functions for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FracBits = 8;
	localparam int DataW    = 32;
	// dividend is |a| << (FracBits + 1): one extra quotient bit for rounding
	localparam int QuoW     = DataW + 1 + FracBits;
	localparam int RemW     = DataW;

	localparam logic [DataW-1:0] MaxVal = 32'h7fff_ffff;
	localparam logic [DataW-1:0] MinVal = 32'h8000_0000;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
		OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_ITOF, OP_TO_INT
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// Payload handed down the divider chain
	typedef struct packed {
		op_t              op;
		logic [DataW-1:0] res;
		logic             cmp;
		status_t          st;
		logic [63:0]      prod;
		logic             neg;
		logic [QuoW-1:0]  quo;
		logic [RemW-1:0]  rem;
		logic [DataW-1:0] den;
	} item_t;

	typedef struct packed {
		logic [DataW-1:0] val;
		status_t          st;
	} sat_t;

	// Signed magnitude to 32-bit two's complement, saturating
	function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
		sat_t r;
		r.st = ST_OK;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) begin
				r.val = MinVal;
				r.st  = ST_OVF;
			end else begin
				r.val = 32'd0 - m[DataW-1:0];
			end
		end else begin
			if (m > 64'h0000_0000_7fff_ffff) begin
				r.val = MaxVal;
				r.st  = ST_OVF;
			end else begin
				r.val = m[DataW-1:0];
			end
		end
		return r;
	endfunction

	// 33-bit sum to 32 bits, saturating
	function automatic sat_t sat_sum(input logic [DataW:0] s);
		sat_t r;
		r.st  = ST_OK;
		r.val = s[DataW-1:0];
		if (s[DataW] != s[DataW-1]) begin
			r.st  = ST_OVF;
			r.val = s[DataW] ? MinVal : MaxVal;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fpa_pre.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pre
// Input register, simple operations, multiplier and divider setup.
// ----------------------------------------------------------------------------
module fpa_pre (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [3:0]                    in_op,
	input  wire logic [fpa_pkg::DataW-1:0]     in_a,
	input  wire logic [fpa_pkg::DataW-1:0]     in_b,
	output logic                               out_valid,
	output fpa_pkg::item_t                     out_item
);
	import fpa_pkg::*;

	logic             valid_s1;
	op_t              op_s1;
	logic [DataW-1:0] a_s1, b_s1;
	logic             valid_s2;
	item_t            item_s2;
	item_t            item_d;
	logic [DataW-1:0] mag_a, mag_b;
	logic             a_lt_b, a_eq_b;
	sat_t             sr;

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_t'(in_op);
			a_s1  <= in_a;
			b_s1  <= in_b;
		end
	end

	// operation decode
	always_comb begin
		mag_a  = a_s1[DataW-1] ? 32'd0 - a_s1 : a_s1;
		mag_b  = b_s1[DataW-1] ? 32'd0 - b_s1 : b_s1;
		a_lt_b = $signed(a_s1) < $signed(b_s1);
		a_eq_b = a_s1 == b_s1;
		sr     = '{val: '0, st: ST_OK};

		item_d      = '0;
		item_d.op   = op_s1;
		item_d.prod = 64'($signed(a_s1) * $signed(b_s1));
		item_d.neg  = a_s1[DataW-1] ^ b_s1[DataW-1];
		item_d.quo  = {mag_a, (FracBits + 1)'(0)};
		item_d.den  = mag_b;

		case (op_s1)
			OP_ADD: sr = sat_sum({a_s1[DataW-1], a_s1} + {b_s1[DataW-1], b_s1});
			OP_SUB: sr = sat_sum({a_s1[DataW-1], a_s1} - {b_s1[DataW-1], b_s1});
			OP_MUL: sr = '{val: '0, st: ST_OK};
			OP_DIV: begin
				if (b_s1 == '0) begin
					sr.st = ST_DIV0;
					if (a_s1 == '0)           sr.val = '0;
					else if (a_s1[DataW-1])   sr.val = MinVal;
					else                      sr.val = MaxVal;
				end
			end
			OP_GT:     item_d.cmp = !a_lt_b && !a_eq_b;
			OP_LT:     item_d.cmp = a_lt_b;
			OP_GE:     item_d.cmp = !a_lt_b;
			OP_LE:     item_d.cmp = a_lt_b || a_eq_b;
			OP_EQ:     item_d.cmp = a_eq_b;
			OP_NE:     item_d.cmp = !a_eq_b;
			OP_MIN:    sr.val = (a_lt_b || a_eq_b) ? a_s1 : b_s1;
			OP_MAX:    sr.val = !a_lt_b ? a_s1 : b_s1;
			OP_INC:    sr = sat_sum({a_s1[DataW-1], a_s1} + 33'd1);
			OP_DEC:    sr = sat_sum({a_s1[DataW-1], a_s1} - 33'd1);
			OP_ITOF:   sr = sat_mag(64'(mag_a) << FracBits, a_s1[DataW-1]);
			OP_TO_INT: sr.val = DataW'($signed(a_s1) >>> FracBits);
			default:   sr = '{val: '0, st: ST_OK};
		endcase
		item_d.res = sr.val;
		item_d.st  = sr.st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule
`default_nettype wire

// File: hw/rtl/fpa_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module fpa_div_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  fpa_pkg::item_t      in_item,
	output logic                out_valid,
	output fpa_pkg::item_t      out_item
);
	import fpa_pkg::*;

	logic            valid_q;
	item_t           item_q;
	item_t           item_d;
	logic [RemW:0]   shifted;
	logic [RemW+1:0] diff;
	logic            q_bit;

	// shift in next dividend bit, trial subtract
	always_comb begin
		item_d  = in_item;
		shifted = {in_item.rem, in_item.quo[QuoW-1]};
		diff    = {1'b0, shifted} - {2'b00, in_item.den};
		q_bit   = !diff[RemW+1];
		item_d.rem = q_bit ? diff[RemW-1:0] : shifted[RemW-1:0];
		item_d.quo = {in_item.quo[QuoW-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
`default_nettype wire

// File: hw/rtl/fpa_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_post
// Rounding and saturation of multiply and divide, final result select.
// ----------------------------------------------------------------------------
module fpa_post (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  fpa_pkg::item_t                     in_item,
	output logic                               out_valid,
	output logic [fpa_pkg::DataW-1:0]          out_res,
	output logic                               out_cmp,
	output fpa_pkg::status_t                   out_st
);
	import fpa_pkg::*;

	localparam logic [63:0] RndMul = 64'd1 << (FracBits - 1);

	logic             valid_s1, valid_s2;
	op_t              op_s1;
	logic [DataW-1:0] res_s1, res_s2;
	logic             cmp_s1, cmp_s2;
	status_t          st_s1, st_s2;
	logic [63:0]      pmag_s1;
	logic             pneg_s1, neg_s1;
	logic [QuoW-1:0]  qdiv_s1;
	logic [63:0]      qmul;
	sat_t             sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// product magnitude, divide rounding (quotient has one extra bit)
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_item.op;
			res_s1  <= in_item.res;
			cmp_s1  <= in_item.cmp;
			st_s1   <= in_item.st;
			pneg_s1 <= in_item.prod[63];
			pmag_s1 <= in_item.prod[63] ? 64'd0 - in_item.prod : in_item.prod;
			neg_s1  <= in_item.neg;
			qdiv_s1 <= (in_item.quo + QuoW'(1)) >> 1;
		end
	end

	// saturate and select
	always_comb begin
		qmul = (pmag_s1 + RndMul) >> FracBits;
		sr   = '{val: res_s1, st: st_s1};
		if (op_s1 == OP_MUL) begin
			sr = sat_mag(qmul, pneg_s1);
		end else if (op_s1 == OP_DIV && st_s1 != ST_DIV0) begin
			sr = sat_mag(64'(qdiv_s1), neg_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= sr.val;
			st_s2  <= sr.st;
			cmp_s2 <= cmp_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;
	assign out_cmp   = cmp_s2;
	assign out_st    = st_s2;

endmodule
`default_nettype wire

// File: hw/rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU (8 fractional bits), fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one operation per beat: opcode and two raw
//   operands. Master channel m_* returns one result beat per operation, in
//   order: raw result, compare flag and status.
//   Throughput: one beat per cycle while s_tready is high. Every operation
//   takes the same path: input register, setup stage, a chain of 41
//   division cells (one quotient bit each), two rounding/saturation stages
//   and the output register.
//   A two-entry output register/skid pair sits at the end; s_tready is a
//   registered signal that drops only when both entries hold results, which
//   freezes the whole pipeline until the receiver takes a beat.
//   Reset (arst_n low) empties the pipeline and both output entries; s_tready
//   is high right after reset.
// ----------------------------------------------------------------------------
module fixed_point_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // opcode[3:0], operand_a[35:4], operand_b[67:36]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // result_value[31:0], compare_true[32], status[34:33]
);
	import fpa_pkg::*;

	localparam int OutW = DataW + 3;

	logic             en;
	logic             cell_v [0:QuoW];
	item_t            cell_i [0:QuoW];
	logic             post_v;
	logic [DataW-1:0] post_res;
	logic             post_cmp;
	status_t          post_st;
	logic [OutW-1:0]  post_d;
	logic             out_v_q, skid_v_q;
	logic [OutW-1:0]  out_d_q, skid_d_q;
	logic             take;

	// pipeline moves whenever the skid entry is free
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign take     = out_v_q && m_tready;

	fpa_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid && s_tready),
		.in_op     (s_tdata[3:0]),
		.in_a      (s_tdata[35:4]),
		.in_b      (s_tdata[67:36]),
		.out_valid (cell_v[0]),
		.out_item  (cell_i[0])
	);

	// division cell chain
	for (genvar g = 0; g < QuoW; g++) begin : g_cell
		fpa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_v[g]),
			.in_item   (cell_i[g]),
			.out_valid (cell_v[g+1]),
			.out_item  (cell_i[g+1])
		);
	end

	fpa_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cell_v[QuoW]),
		.in_item   (cell_i[QuoW]),
		.out_valid (post_v),
		.out_res   (post_res),
		.out_cmp   (post_cmp),
		.out_st    (post_st)
	);

	assign post_d = {post_st, post_cmp, post_res};

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (post_v) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_d_q <= skid_d_q;
			end
		end else if (post_v) begin
			if (out_v_q && !take) begin
				skid_d_q <= post_d;
			end else begin
				out_d_q <= post_d;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_d_q};

endmodule
`default_nettype wire

// File: hw/rtl/fpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU result stream.
// ----------------------------------------------------------------------------
module fpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	import fpa_pkg::*;

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// input only stalls while a result is waiting
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// a true compare carries a zero result and ok status
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[31:0] == '0 && m_tdata[34:33] == ST_OK)
		else $error("compare beat with nonzero result or status");

	// status code three is never produced
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:33] != 2'd3)
		else $error("illegal status");

	// saturated or divide-by-zero results sit at a rail or zero
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:33] != ST_OK |->
		m_tdata[31:0] == MaxVal || m_tdata[31:0] == MinVal ||
		(m_tdata[34:33] == ST_DIV0 && m_tdata[31:0] == '0))
		else $error("error status with non-rail result");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);
`default_nettype wire

// File: verif/tb_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Stream-level check of the fixed-point ALU. Operations are queued by an
// initial block, sent by a clocked driver with random gaps, and every result
// beat is compared against a built-in exact integer model of each operation.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
	import fpa_pkg::*;

	localparam int Frac = FracBits;
	localparam int NumRandom = 1030;

	// packed to match the result tdata layout, lowest field last
	typedef struct packed {
		logic [1:0]  st;
		logic        cmp;
		logic [31:0] val;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	logic [71:0] pending_ops[$];
	alu_result_t expected_results[$];
	int          errors;
	int          results_seen;
	int          op_count[16];
	bit          stim_done;
	int          send_gap;
	int          take_gap;
	int          hold_cycles;
	bit          hold_done;
	logic        hold_active;
	bit          drain_pause;

	fixed_point_alu DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// saturate a wide signed value to 32 bits
	function automatic logic [33:0] clamp_to_word(input longint v);
		if (v > 64'sd2147483647)
			return {ST_OVF, MaxVal};
		if (v < -64'sd2147483648)
			return {ST_OVF, MinVal};
		return {ST_OK, v[31:0]};
	endfunction

	// exact result of one operation
	function automatic alu_result_t alu_predict(input logic [3:0] opc,
			input logic signed [31:0] a32, input logic signed [31:0] b32);
		alu_result_t r;
		longint a, b, p, q, s;
		longint unsigned m, num, den;
		logic [33:0] c;
		a = a32;
		b = b32;
		r = '0;
		c = {ST_OK, 32'd0};
		case (op_t'(opc))
			OP_ADD: c = clamp_to_word(a + b);
			OP_SUB: c = clamp_to_word(a - b);
			OP_MUL: begin
				p = a * b;
				m = (p < 0) ? -p : p;
				q = (m + (64'd1 << (Frac - 1))) >> Frac;
				c = clamp_to_word(p < 0 ? -q : q);
			end
			OP_DIV: begin
				if (b == 0) begin
					c[33:32] = ST_DIV0;
					c[31:0] = (a > 0) ? MaxVal : ((a < 0) ? MinVal : 32'd0);
				end else begin
					num = ((a < 0) ? -a : a) << Frac;
					den = (b < 0) ? -b : b;
					q = (2 * num + den) / (2 * den);
					c = clamp_to_word(((a < 0) != (b < 0)) ? -q : q);
				end
			end
			OP_GT: r.cmp = a > b;
			OP_LT: r.cmp = a < b;
			OP_GE: r.cmp = a >= b;
			OP_LE: r.cmp = a <= b;
			OP_EQ: r.cmp = a == b;
			OP_NE: r.cmp = a != b;
			OP_MIN: c[31:0] = (a <= b) ? a32 : b32;
			OP_MAX: c[31:0] = (a >= b) ? a32 : b32;
			OP_INC: c = clamp_to_word(a + 1);
			OP_DEC: c = clamp_to_word(a - 1);
			OP_ITOF: begin
				s = a * (64'sd1 << Frac);
				c = clamp_to_word(s);
			end
			default: c[31:0] = a32 >>> Frac;
		endcase
		r.val = c[31:0];
		r.st = c[33:32];
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return MaxVal - $urandom_range(0, 3);
			1: return MinVal + $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
			3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
			4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(input op_t opc, input logic [31:0] a, input logic [31:0] b);
		pending_ops.push_back({4'd0, b, a, opc});
	endtask

	// stimulus
	initial begin
		op_t o;
		arst_n = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		drain_pause = 1'b0;
		// every operation on extreme operands, then chosen corner and everyday cases
		for (int i = 0; i < 16; i++) begin
			o = op_t'(i);
			push_op(o, MaxVal, MinVal);
		end
		push_op(OP_DIV, 32'd0, 32'd0);
		push_op(OP_DIV, 32'd1000, 32'd0);
		push_op(OP_DIV, MinVal, 32'd0);
		push_op(OP_DIV, 32'h180, 32'h100);
		push_op(OP_MUL, 32'h080, 32'h001);
		push_op(OP_MUL, 32'hffff_ff80, 32'h001);
		push_op(OP_MUL, MinVal, MinVal);
		push_op(OP_SUB, MinVal, 32'd1);
		push_op(OP_TO_INT, 32'hffff_ff01, 32'd0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom / 2) begin
				// let the pipeline empty completely before continuing
				wait (pending_ops.size() == 0);
				drain_pause = 1'b1;
				wait (expected_results.size() == 0);
				drain_pause = 1'b0;
			end
			push_op(op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
		end
		stim_done = 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(alu_predict(s_tdata[3:0], s_tdata[35:4],
					s_tdata[67:36]));
				op_count[s_tdata[3:0]]++;
			end
			if (s_tvalid && !s_tready) begin
				// keep offering the same beat
			end else if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_ops.size() > 0 && !drain_pause) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_ops.pop_front();
				send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off once 300 results are in, so the pipeline backs up
	assign hold_active = (results_seen >= 300) && !hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (hold_active) begin
			if (hold_cycles == 199)
				hold_done <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		alu_result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap <= 0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[34:0];
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: val exp %h got %h, cmp exp %b got %b, st exp %0d got %0d",
								want.val, got.val, want.cmp, got.cmp, want.st, got.st);
					end
				end
			end
			if (hold_active) begin
				m_tready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && results_seen > 600 && results_seen < 900)
					take_gap <= 0;
				else if (m_tvalid && $urandom_range(0, 3) == 0)
					take_gap <= $urandom_range(0, 16);
			end
		end
	end

	// end of run
	initial begin
		int min_ops;
		wait (stim_done && pending_ops.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (60) @(posedge clk);
		min_ops = op_count[0];
		for (int i = 1; i < 16; i++)
			if (op_count[i] < min_ops)
				min_ops = op_count[i];
		$display("Ran %0d operations over all 16 opcodes (min per opcode %0d) with random stalls.",
			results_seen, min_ops);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout");
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_pre.sv
hw/rtl/fpa_div_cell.sv
hw/rtl/fpa_post.sv
hw/rtl/fixed_point_alu.sv
hw/rtl/fpa_checker.sv
verif/tb_fixed_point_alu.sv
